// ===== rtl/core/pcf_pkg.sv =====
// PNG chunk framer package: command and error codes, CRC-32 constants and
// the byte-wide reflected CRC-32 update. No dependencies.
`timescale 1ns / 1ps

package pcf_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // header bytes held in the byte buffer; CRC bytes are read from the CRC register
  localparam int unsigned BUF_BYTES = 8;
  localparam int unsigned CRC_BYTES = 4;
  localparam int unsigned CNT_W     = $clog2(BUF_BYTES + CRC_BYTES + 1);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_NO_CHUNK   = 2'd1,
    ERR_CHUNK_OPEN = 2'd2
  } err_e;

  function automatic logic [31:0] crc_fold8(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/png_chunk_framer_crc32.sv =====
// The first result word of an item is loaded into the byte buffer and then into the output register.
// One word per cycle goes out while out_stall_i is low; a data word that keeps the chunk open
// yields 1 byte, one that closes it 5, a start 8 (12 for a zero length chunk), an error word 1.
// The byte buffer drains into the output register; a new item is accepted once it is empty or its last byte pops.
// Type CRC is folded a byte per cycle: the first byte as a start is accepted, the other three after it.
// Reset (rst_ni, async, active low): no chunk open, buffer and output empty.
`timescale 1ns / 1ps

module png_chunk_framer_crc32
  import pcf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [31:0] type_code_i,
  input  logic [30:0] body_len_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        chunk_end_o,
  output logic [1:0]  error_code_o
);

  localparam int unsigned BUF_W = BUF_BYTES * 8;

  // chunk state
  logic              open_q, open_d;
  logic [30:0]       rem_q, rem_d;
  logic [31:0]       crc_q, crc_d;
  logic [23:0]       type_q, type_d;
  logic [1:0]        tstep_q, tstep_d;

  // byte buffer for the item in flight
  logic [BUF_W-1:0]  buf_q, buf_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              has_crc_q, has_crc_d;
  err_e              err_q, err_d;

  // output register
  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              run_last_q, chunk_end_q;
  err_e              out_err_q;

  logic              adv, pop, accept;
  logic [31:0]       crc_inv, data_crc;
  logic [7:0]        crc_byte, pop_byte;

  assign adv        = !out_valid_q || !out_stall_i;
  assign pop        = adv && (cnt_q != '0);
  assign in_stall_o = !((cnt_q == '0) || ((cnt_q == CNT_W'(1)) && adv));
  assign accept     = in_valid_i && !in_stall_o;

  assign data_crc = crc_fold8(crc_q, data_byte_i);
  assign crc_inv  = ~crc_q;

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    crc_byte = crc_inv[31:24];
      2'd3:    crc_byte = crc_inv[23:16];
      2'd2:    crc_byte = crc_inv[15:8];
      default: crc_byte = crc_inv[7:0];
    endcase
  end

  assign pop_byte = (has_crc_q && (cnt_q <= CNT_W'(CRC_BYTES))) ? crc_byte
                                                                 : buf_q[BUF_W-1 -: 8];

  always_comb begin
    open_d    = open_q;
    rem_d     = rem_q;
    crc_d     = crc_q;
    type_d    = type_q;
    tstep_d   = tstep_q;
    buf_d     = buf_q;
    cnt_d     = cnt_q;
    has_crc_d = has_crc_q;
    err_d     = err_q;

    if (pop) begin
      buf_d = {buf_q[BUF_W-9:0], 8'd0};
      cnt_d = cnt_q - CNT_W'(1);
    end

    if (tstep_q != 2'd0) begin
      crc_d   = crc_fold8(crc_q, type_q[23:16]);
      type_d  = {type_q[15:0], 8'd0};
      tstep_d = tstep_q - 2'd1;
    end

    if (accept) begin
      has_crc_d = 1'b0;
      err_d     = ERR_NONE;
      buf_d     = '0;
      if (command_i == CMD_START) begin
        if (open_q) begin
          err_d = ERR_CHUNK_OPEN;
          cnt_d = CNT_W'(1);
        end else begin
          buf_d   = {1'b0, body_len_i, type_code_i};
          crc_d   = crc_fold8(CRC_INIT, type_code_i[31:24]);
          type_d  = type_code_i[23:0];
          tstep_d = 2'd3;
          rem_d   = body_len_i;
          if (body_len_i == 31'd0) begin
            cnt_d     = CNT_W'(BUF_BYTES + CRC_BYTES);
            has_crc_d = 1'b1;
          end else begin
            cnt_d  = CNT_W'(BUF_BYTES);
            open_d = 1'b1;
          end
        end
      end else begin
        if (!open_q) begin
          err_d = ERR_NO_CHUNK;
          cnt_d = CNT_W'(1);
        end else begin
          buf_d = {data_byte_i, {(BUF_W-8){1'b0}}};
          crc_d = data_crc;
          rem_d = rem_q - 31'd1;
          if (rem_q == 31'd1) begin
            cnt_d     = CNT_W'(1 + CRC_BYTES);
            has_crc_d = 1'b1;
            open_d    = 1'b0;
          end else begin
            cnt_d = CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      rem_q       <= '0;
      crc_q       <= CRC_INIT;
      tstep_q     <= 2'd0;
      cnt_q       <= '0;
      has_crc_q   <= 1'b0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      open_q    <= open_d;
      rem_q     <= rem_d;
      crc_q     <= crc_d;
      tstep_q   <= tstep_d;
      cnt_q     <= cnt_d;
      has_crc_q <= has_crc_d;
      err_q     <= err_d;
      if (adv) begin
        out_valid_q <= pop;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d;
    buf_q  <= buf_d;
    if (pop) begin
      out_byte_q  <= pop_byte;
      run_last_q  <= (cnt_q == CNT_W'(1));
      chunk_end_q <= has_crc_q && (cnt_q == CNT_W'(1));
      out_err_q   <= err_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = run_last_q;
  assign chunk_end_o  = chunk_end_q;
  assign error_code_o = out_err_q;

  // type CRC must be complete before its bytes are read
  a_type_crc_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tstep_q != 2'd0) |-> (cnt_q > CNT_W'(CRC_BYTES)))
    else $error("type CRC still folding when CRC bytes are due");

  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (cnt_q != '0))
    else $error("accepted word left the buffer empty");

  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && chunk_end_o) |-> (run_last_o && (error_code_o == ERR_NONE)))
    else $error("chunk end not on the last word of an item");

  a_err_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (error_code_o != ERR_NONE)) |-> (run_last_o && (out_byte_o == 8'd0)))
    else $error("error result malformed");

endmodule
